>>> rtl/etbcr_pkg.sv
package etbcr_pkg;

    // Field widths
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned OUT_W   = 40;

    // Item kind carried in tuser
    typedef enum logic [0:0] {
        CMD_EDGE = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    // Register indexes on the config port
    typedef enum logic [IDX_W-1:0] {
        REG_SYM_LEN       = 2'd0,
        REG_SYM_TOL       = 2'd1,
        REG_SAMPLE_PERIOD = 2'd2,
        REG_LOSS_LIMIT    = 2'd3
    } t_reg_idx;

    // Settings seen by the core, with the edge window precomputed
    typedef struct packed {
        logic [TIME_W-1:0]  sym_len;
        logic [TIME_W-1:0]  sample_period;
        logic [COUNT_W-1:0] loss_limit;
        logic [TIME_W-1:0]  win_lo;
        logic [TIME_W:0]    win_hi;
    } t_cfg;

    // One result word
    typedef struct packed {
        logic              compare_write;
        logic [TIME_W-1:0] compare_time;
        logic              bit_valid;
        logic              nrzi_bit;
        logic              level_now;
        logic              level_before;
        logic              in_sync;
    } t_result;

endpackage

>>> rtl/etbcr_cfg.sv
module etbcr_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [etbcr_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [etbcr_pkg::CFG_W-1:0]    i_cfg_data,
    output etbcr_pkg::t_cfg                o_cfg
);

    logic [etbcr_pkg::TIME_W-1:0]  r_sym_len;
    logic [etbcr_pkg::TIME_W-1:0]  r_sym_tol;
    logic [etbcr_pkg::TIME_W-1:0]  r_sample_period;
    logic [etbcr_pkg::COUNT_W-1:0] r_loss_limit;
    logic [etbcr_pkg::TIME_W-1:0]  r_win_lo;
    logic [etbcr_pkg::TIME_W:0]    r_win_hi;
    logic [etbcr_pkg::TIME_W-1:0]  n_win_lo;
    logic [etbcr_pkg::TIME_W:0]    n_win_hi;

    // Store register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_len       <= '0;
            r_sym_tol       <= '0;
            r_sample_period <= '0;
            r_loss_limit    <= '0;
        end else if (i_cfg_we) begin
            unique case (etbcr_pkg::t_reg_idx'(i_cfg_index))
                etbcr_pkg::REG_SYM_LEN:       r_sym_len       <= i_cfg_data;
                etbcr_pkg::REG_SYM_TOL:       r_sym_tol       <= i_cfg_data;
                etbcr_pkg::REG_SAMPLE_PERIOD: r_sample_period <= i_cfg_data;
                etbcr_pkg::REG_LOSS_LIMIT:
                    r_loss_limit <= i_cfg_data[etbcr_pkg::COUNT_W-1:0];
            endcase
        end
    end

    // Window bounds: lower saturates at zero, upper keeps the carry
    always_comb begin
        n_win_lo = (r_sym_tol > r_sym_len) ? '0
                   : r_sym_len - r_sym_tol;
        n_win_hi = {1'b0, r_sym_len} + {1'b0, r_sym_tol};
    end

    // Hold the bounds in registers to keep the add off the item path
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_lo <= '0;
            r_win_hi <= '0;
        end else begin
            r_win_lo <= n_win_lo;
            r_win_hi <= n_win_hi;
        end
    end

    assign o_cfg.sym_len       = r_sym_len;
    assign o_cfg.sample_period = r_sample_period;
    assign o_cfg.loss_limit    = r_loss_limit;
    assign o_cfg.win_lo        = r_win_lo;
    assign o_cfg.win_hi        = r_win_hi;

endmodule

>>> rtl/etbcr_core.sv
module etbcr_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  etbcr_pkg::t_cmd               i_cmd,
    input  logic [etbcr_pkg::TIME_W-1:0]  i_time,
    input  etbcr_pkg::t_cfg               i_cfg,
    output etbcr_pkg::t_result            o_result
);

    logic [etbcr_pkg::TIME_W-1:0]  r_rise_time;
    logic [etbcr_pkg::TIME_W-1:0]  r_fall_time;
    logic                          r_rise_seen;
    logic                          r_fall_seen;
    logic                          r_expect_rising;
    logic                          r_level_current;
    logic                          r_level_held;
    logic                          r_synced;
    logic [etbcr_pkg::COUNT_W-1:0] r_ticks;
    logic [etbcr_pkg::TIME_W-1:0]  r_next_time;

    logic [etbcr_pkg::TIME_W-1:0]  n_rise_time;
    logic [etbcr_pkg::TIME_W-1:0]  n_fall_time;
    logic                          n_rise_seen;
    logic                          n_fall_seen;
    logic                          n_expect_rising;
    logic                          n_level_current;
    logic                          n_level_held;
    logic                          n_synced;
    logic [etbcr_pkg::COUNT_W-1:0] n_ticks;
    logic [etbcr_pkg::TIME_W-1:0]  n_next_time;

    logic [etbcr_pkg::TIME_W-1:0]  gap;
    logic                          gap_ok;
    logic                          edge_hit;
    logic [etbcr_pkg::COUNT_W-1:0] ticks_inc;

    // Gap to the opposite edge and window test
    always_comb begin
        gap      = r_expect_rising ? i_time - r_fall_time : i_time - r_rise_time;
        gap_ok   = (i_cfg.win_lo < gap) && ({1'b0, gap} < i_cfg.win_hi);
        edge_hit = (r_expect_rising ? r_fall_seen : r_rise_seen) && gap_ok;
        ticks_inc = r_ticks + 1'b1;
    end

    // Next state and result for the current word
    always_comb begin
        n_rise_time     = r_rise_time;
        n_fall_time     = r_fall_time;
        n_rise_seen     = r_rise_seen;
        n_fall_seen     = r_fall_seen;
        n_expect_rising = r_expect_rising;
        n_level_current = r_level_current;
        n_level_held    = r_level_held;
        n_synced        = r_synced;
        n_ticks         = r_ticks;
        n_next_time     = r_next_time;

        o_result.compare_write = 1'b0;
        o_result.bit_valid     = 1'b0;
        o_result.nrzi_bit      = 1'b0;
        o_result.level_before  = r_level_held;

        unique case (i_cmd)
            etbcr_pkg::CMD_EDGE: begin
                n_level_current = r_expect_rising;
                n_expect_rising = !r_expect_rising;
                if (r_expect_rising) begin
                    n_rise_time = i_time;
                    n_rise_seen = 1'b1;
                end else begin
                    n_fall_time = i_time;
                    n_fall_seen = 1'b1;
                end
                if (edge_hit) begin
                    n_next_time = i_time + (r_synced ? i_cfg.sample_period
                                                     : i_cfg.sym_len);
                    n_ticks     = '0;
                    n_synced    = 1'b1;
                    o_result.compare_write = 1'b1;
                end
            end
            etbcr_pkg::CMD_TICK: begin
                o_result.compare_write = 1'b1;
                if (r_synced) begin
                    o_result.bit_valid = 1'b1;
                    o_result.nrzi_bit  = (r_level_current == r_level_held);
                    n_next_time = r_next_time + i_cfg.sample_period;
                end else begin
                    n_next_time = '0;
                end
                n_ticks      = ticks_inc;
                n_synced     = r_synced && (ticks_inc < i_cfg.loss_limit);
                n_level_held = r_level_current;
            end
        endcase

        o_result.compare_time = n_next_time;
        o_result.level_now    = n_level_current;
        o_result.in_sync      = n_synced;
    end

    // Advance state on each processed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_time     <= '0;
            r_fall_time     <= '0;
            r_rise_seen     <= 1'b0;
            r_fall_seen     <= 1'b0;
            r_expect_rising <= 1'b1;
            r_level_current <= 1'b0;
            r_level_held    <= 1'b0;
            r_synced        <= 1'b0;
            r_ticks         <= '0;
            r_next_time     <= '0;
        end else if (i_step) begin
            r_rise_time     <= n_rise_time;
            r_fall_time     <= n_fall_time;
            r_rise_seen     <= n_rise_seen;
            r_fall_seen     <= n_fall_seen;
            r_expect_rising <= n_expect_rising;
            r_level_current <= n_level_current;
            r_level_held    <= n_level_held;
            r_synced        <= n_synced;
            r_ticks         <= n_ticks;
            r_next_time     <= n_next_time;
        end
    end

    // Edges alternate polarity
    a_edge_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (i_cmd == etbcr_pkg::CMD_EDGE)
        |=> r_expect_rising != $past(r_expect_rising))
        else $error("edge did not toggle expected polarity");

    // Unsynced tick clears the schedule
    a_tick_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (i_cmd == etbcr_pkg::CMD_TICK) && !r_synced
        |=> r_next_time == '0)
        else $error("unsynced tick left a sample time");

    // Tick latches the current level
    a_tick_holds_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (i_cmd == etbcr_pkg::CMD_TICK)
        |=> r_level_held == $past(r_level_current))
        else $error("tick did not hold the line level");

    // Valid edge locks and restarts the loss count
    a_edge_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (i_cmd == etbcr_pkg::CMD_EDGE) && edge_hit
        |=> r_synced && (r_ticks == '0))
        else $error("valid edge did not lock");

endmodule

>>> rtl/edge_timed_bit_clock_recovery.sv
// Edge-timed bit clock recovery with NRZI bit sampling.
//
// Input stream (s_*): one word per event. s_tuser selects the kind: a captured
// line edge or a sample compare tick. s_tdata carries the edge timestamp.
// Output stream (m_*): exactly one result word per input word, in order:
// the updated compare time, whether it was rewritten, the sampled NRZI bit
// and its valid flag, both line levels and the sync flag.
// Config port: write enable, register index and data; write only while idle.
//
// An accepted word sits in the input register; the core update then runs it
// into the output register. Throughput is one word per cycle while m_tready
// stays high, set by the combinational core update between the two
// registers. A word is taken while the input register is empty or its word
// moves on to the output register; when m_tready is low both registers fill
// and s_tready drops.
// Reset (synchronous, active low) clears both registers, all settings and
// the tracking state; expected polarity starts at rising.
module edge_timed_bit_clock_recovery (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [etbcr_pkg::TIME_W-1:0]  s_tdata,  // [31:0] edge_time
    input  logic                          s_tuser,  // [0] command
    // master stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] compare_write, [32:1] compare_time, [33] bit_valid, [34] nrzi_bit,
    // [35] level_now, [36] level_before, [37] in_sync, [39:38] zero
    output logic [etbcr_pkg::OUT_W-1:0]   m_tdata,
    // config port
    input  logic                          i_cfg_we,
    input  logic [etbcr_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [etbcr_pkg::CFG_W-1:0]   i_cfg_data
);

    logic                          r_in_valid;
    etbcr_pkg::t_cmd               r_in_cmd;
    logic [etbcr_pkg::TIME_W-1:0]  r_in_time;
    logic                          r_out_valid;
    etbcr_pkg::t_result            r_out;
    logic                          advance;
    logic                          step;
    etbcr_pkg::t_cfg               cfg;
    etbcr_pkg::t_result            result;

    assign advance  = !r_out_valid || m_tready;
    assign step     = r_in_valid && advance;
    assign s_tready = !r_in_valid || advance;

    etbcr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    etbcr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_cmd    (r_in_cmd),
        .i_time   (r_in_time),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register: take a word when empty or moving on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_cmd  <= etbcr_pkg::t_cmd'(s_tuser);
            r_in_time <= s_tdata;
        end
    end

    // Output register: load on step, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {2'b00, r_out.in_sync, r_out.level_before, r_out.level_now,
                       r_out.nrzi_bit, r_out.bit_valid, r_out.compare_time,
                       r_out.compare_write};

endmodule

>>> test/tb_top.sv
module tb_top;

    localparam int STALL_LIMIT = 3000;  // cycles with no word moving on either side
    localparam int HOLD_CYCLES = 200;   // long receiver hold-off
    localparam int NO_HOLD     = 1 << 30;
    localparam int MAX_REPORTS = 40;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [etbcr_pkg::TIME_W-1:0]   s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [etbcr_pkg::OUT_W-1:0]    m_tdata;
    logic                           i_cfg_we;
    logic [etbcr_pkg::IDX_W-1:0]    i_cfg_index;
    logic [etbcr_pkg::CFG_W-1:0]    i_cfg_data;

    // Tracks the recovery state and queues the result word each input word should give
    class bitclk_scoreboard;
        bit [31:0] sym_len, sym_tol, sample_period;
        bit [7:0]  loss_limit;
        bit [31:0] rise_stamp, fall_stamp, sample_at;
        bit        rise_seen, fall_seen, want_rise, line_level, held_level, locked;
        bit [7:0]  tick_count;
        etbcr_pkg::t_result result_q[$];
        int        errors;

        function new();
            sym_len       = '0;
            sym_tol       = '0;
            sample_period = '0;
            loss_limit    = '0;
            rise_stamp    = '0;
            fall_stamp    = '0;
            sample_at     = '0;
            rise_seen     = 1'b0;
            fall_seen     = 1'b0;
            want_rise     = 1'b1;
            line_level    = 1'b0;
            held_level    = 1'b0;
            locked        = 1'b0;
            tick_count    = '0;
            errors        = 0;
        endfunction

        function void set_reg(etbcr_pkg::t_reg_idx idx, bit [31:0] value);
            case (idx)
                etbcr_pkg::REG_SYM_LEN:       sym_len       = value;
                etbcr_pkg::REG_SYM_TOL:       sym_tol       = value;
                etbcr_pkg::REG_SAMPLE_PERIOD: sample_period = value;
                etbcr_pkg::REG_LOSS_LIMIT:    loss_limit    = value[7:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return result_q.size();
        endfunction

        // Advance the state by one accepted input word
        function void note_word(etbcr_pkg::t_cmd cmd, bit [31:0] stamp);
            etbcr_pkg::t_result res;
            bit [31:0] gap, win_lo;
            bit [32:0] win_hi;
            res = '0;
            res.level_before = held_level;
            if (cmd == etbcr_pkg::CMD_EDGE) begin
                line_level = want_rise;
                if (want_rise) begin
                    rise_stamp = stamp;
                    rise_seen  = 1'b1;
                    gap        = rise_stamp - fall_stamp;
                end else begin
                    fall_stamp = stamp;
                    fall_seen  = 1'b1;
                    gap        = fall_stamp - rise_stamp;
                end
                want_rise = !want_rise;
                // open window, low end saturated at zero, high end in 33 bits
                win_lo = (sym_tol > sym_len) ? 32'd0 : sym_len - sym_tol;
                win_hi = {1'b0, sym_len} + {1'b0, sym_tol};
                if (rise_seen && fall_seen && (win_lo < gap) && ({1'b0, gap} < win_hi)) begin
                    sample_at         = stamp + (locked ? sample_period : sym_len);
                    res.compare_write = 1'b1;
                    tick_count        = '0;
                    locked            = 1'b1;
                end
            end else begin
                res.compare_write = 1'b1;
                if (locked) begin
                    res.bit_valid = 1'b1;
                    res.nrzi_bit  = (line_level == held_level);
                    sample_at     = sample_at + sample_period;
                end else begin
                    sample_at = '0;
                end
                tick_count = tick_count + 8'd1;
                if (tick_count >= loss_limit)
                    locked = 1'b0;
                held_level = line_level;
            end
            res.compare_time = sample_at;
            res.level_now    = line_level;
            res.in_sync      = locked;
            result_q.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            end
        endfunction

        // Compare one accepted result word with the oldest expected one
        function void check_word(logic [etbcr_pkg::OUT_W-1:0] word);
            etbcr_pkg::t_result want;
            if (result_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result word with none expected, expected none, got %h",
                             $time, word);
                return;
            end
            want = result_q.pop_front();
            compare_field("compare_write", want.compare_write, word[0]);
            compare_field("compare_time",  want.compare_time,  word[32:1]);
            compare_field("bit_valid",     want.bit_valid,     word[33]);
            compare_field("nrzi_bit",      want.nrzi_bit,      word[34]);
            compare_field("level_now",     want.level_now,     word[35]);
            compare_field("level_before",  want.level_before,  word[36]);
            compare_field("in_sync",       want.in_sync,       word[37]);
        endfunction
    endclass

    bitclk_scoreboard sb = new();

    int          hold_req = 0;   // long hold-offs requested by the sender side
    int          hold_done = 0;  // long hold-offs served by the receiver
    bit          no_idle;    // run both sides without gaps
    bit [31:0]   line_t;     // running line timer for well-formed edges
    bit [31:0]   cur_period, cur_margin;
    int          quiet_cycles = 0;

    edge_timed_bit_clock_recovery i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Mostly short gaps, a few long ones, none while running flat out
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Record both handshakes at each edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_word(etbcr_pkg::t_cmd'(s_tuser), s_tdata);
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata);
        end
    end

    // Stop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Receiver: random ready and stall runs, plus one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_done != hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done++;
            end else if (no_idle) begin
                m_tready <= 1'b1;
                @(posedge i_clk);
            end else begin
                int stall;
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                stall = idle_len();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    // Offer one word and hold it until taken
    task automatic send_word(input etbcr_pkg::t_cmd cmd, input logic [31:0] stamp);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= stamp;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic write_reg(input etbcr_pkg::t_reg_idx idx, input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        sb.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] period, margin, sample,
                              input logic [7:0] loss);
        write_reg(etbcr_pkg::REG_SYM_LEN, period);
        write_reg(etbcr_pkg::REG_SYM_TOL, margin);
        write_reg(etbcr_pkg::REG_SAMPLE_PERIOD, sample);
        write_reg(etbcr_pkg::REG_LOSS_LIMIT, {24'd0, loss});
        i_cfg_we   <= 1'b0;
        cur_period = period;
        cur_margin = margin;
    endtask

    // Drop valid and wait for every expected result plus the pipeline depth
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly edge trains with gaps around the symbol period, ticks between them
    task automatic send_traffic(input int n_items, input int hold_after);
        int               sent;
        int               r;
        int               ticks;
        longint unsigned  lo, hi, gap;
        sent = 0;
        lo   = (cur_margin > cur_period) ? 64'd0 : cur_period - cur_margin;
        hi   = longint'(cur_period) + longint'(cur_margin);
        while (sent < n_items) begin
            if (sent >= hold_after && hold_after != NO_HOLD) begin
                hold_req++;
                hold_after = NO_HOLD;
            end
            r = $urandom_range(0, 99);
            if (r < 8) begin
                // noise: any kind, any stamp
                send_word(etbcr_pkg::t_cmd'($urandom_range(0, 1)), $urandom);
                sent++;
            end else begin
                if (r < 16)
                    gap = {$urandom, $urandom};
                else if (r < 26) begin
                    case ($urandom_range(0, 3))
                        0:       gap = lo;
                        1:       gap = lo + 1;
                        2:       gap = hi - 1;
                        default: gap = hi;
                    endcase
                end else if (hi > lo + 1)
                    gap = lo + 1 + ({$urandom, $urandom} % (hi - lo - 1));
                else
                    gap = lo;
                line_t = line_t + gap[31:0];
                send_word(etbcr_pkg::CMD_EDGE, line_t);
                sent++;
                ticks = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2)
                                                   : $urandom_range(3, 12);
                repeat (ticks) begin
                    send_word(etbcr_pkg::CMD_TICK, $urandom);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        s_tvalid    <= 1'b0;
        s_tuser     <= etbcr_pkg::CMD_EDGE;
        s_tdata     <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= etbcr_pkg::REG_SYM_LEN;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        no_idle     = 1'b0;
        line_t      = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: window edges, sync, loss, timestamp wrap
        set_config(32'd1000, 32'd100, 32'd1000, 8'd4);
        send_word(etbcr_pkg::CMD_EDGE, 32'd0);            // first rise, no fall seen yet
        send_word(etbcr_pkg::CMD_TICK, 32'hFFFF_FFFF);    // tick while unsynced
        send_word(etbcr_pkg::CMD_EDGE, 32'd1000);         // gap inside window: sync
        send_word(etbcr_pkg::CMD_TICK, 32'd0);
        send_word(etbcr_pkg::CMD_TICK, 32'd0);
        send_word(etbcr_pkg::CMD_EDGE, 32'd1900);         // gap equals low bound: rejected
        send_word(etbcr_pkg::CMD_EDGE, 32'd3000);         // gap equals high bound: rejected
        send_word(etbcr_pkg::CMD_EDGE, 32'd4099);         // just inside high bound, synced
        send_word(etbcr_pkg::CMD_EDGE, 32'd5000);         // just inside low bound
        repeat (5) send_word(etbcr_pkg::CMD_TICK, $urandom);  // run into the loss limit
        send_word(etbcr_pkg::CMD_EDGE, 32'hFFFF_FE00);
        send_word(etbcr_pkg::CMD_EDGE, 32'h0000_01F0);    // gap valid across the wrap
        send_word(etbcr_pkg::CMD_TICK, 32'hFFFF_FFFF);
        send_word(etbcr_pkg::CMD_TICK, 32'd0);
        send_word(etbcr_pkg::CMD_EDGE, 32'hFFFF_FFFF);
        send_word(etbcr_pkg::CMD_EDGE, 32'd0);            // gap of one
        send_word(etbcr_pkg::CMD_TICK, 32'hFFFF_FFFF);
        settle();

        // Nominal settings, timer starting close to wrap
        set_config(32'd1000, 32'd100, 32'd990, 8'd8);
        line_t = 32'hFFFF_F000;
        send_traffic(240, NO_HOLD);
        settle();

        // All zero: empty window, sync never set, loss on every tick
        set_config(32'd0, 32'd0, 32'd0, 8'd0);
        send_traffic(60, NO_HOLD);
        settle();

        // All ones: window covers every nonzero gap, widest loss limit
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        line_t = $urandom;
        send_traffic(150, NO_HOLD);
        settle();

        // Margin above period saturates the low bound; no idling on either side
        no_idle = 1'b1;
        set_config(32'd40, 32'd90, 32'd37, 8'd3);
        send_traffic(150, NO_HOLD);
        settle();
        no_idle = 1'b0;

        // Random settings, with one long receiver hold-off
        begin
            logic [31:0] period;
            period = $urandom_range(20, 200000);
            set_config(period, $urandom_range(0, period / 4),
                       period + $urandom_range(0, 20) - 10, 8'($urandom_range(1, 20)));
            send_traffic(300, 40);
        end
        settle();

        if (sb.pending() != 0)
            sb.errors++;
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
rtl/etbcr_pkg.sv
rtl/etbcr_cfg.sv
rtl/etbcr_core.sv
rtl/edge_timed_bit_clock_recovery.sv
test/tb_top.sv
